// ===== hw/rtl/ida_pkg.sv =====
// Shared constants and types for the integer to decimal ASCII converter.
package ida_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);

  // floor(x * RECIP_TEN / 2**RECIP_SHIFT) equals floor(x / 10) for every 32-bit x.
  localparam logic [DATA_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SHIFT = 35;
  localparam int unsigned       QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/ida_div10.sv =====
// Shared divide-by-ten unit: registered reciprocal multiply, then quotient and remainder.
module ida_div10 (
  input  logic                        clk,
  input  logic                        load,
  input  logic [ida_pkg::DATA_W-1:0]  dividend,
  output logic [ida_pkg::DATA_W-1:0]  quotient,
  output logic [ida_pkg::DIGIT_W-1:0] remainder
);
  import ida_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] dividend_q;
  logic [DATA_W-1:0] times_ten;
  logic [DATA_W-1:0] diff;

  always_ff @(posedge clk) begin
    if (load) begin
      prod       <= {{DATA_W{1'b0}}, dividend} * {{DATA_W{1'b0}}, RECIP_TEN};
      dividend_q <= dividend;
    end
  end

  assign quotient  = {{(DATA_W - QUOT_W){1'b0}}, prod[PROD_W-1:RECIP_SHIFT]};
  assign times_ten = {quotient[DATA_W-4:0], 3'b000} + {quotient[DATA_W-2:0], 1'b0};
  assign diff      = dividend_q - times_ten;
  assign remainder = diff[DIGIT_W-1:0];

endmodule

// ===== hw/rtl/int_to_decimal_ascii.sv =====
// After acceptance the magnitude is divided by ten repeatedly, one digit per pass, until the quotient is zero.
// Each digit takes one pass through the shared divide-by-ten unit, in two states (multiply, then remainder).
// Characters then leave at one per cycle while the consumer keeps ready high.
// A negative value sends a minus sign before its digits; at most ten digits follow.
// Reset is synchronous and active high; it returns the sequencer to idle and drops char_valid.
// The next value is accepted while the last character still waits in the output register.
module int_to_decimal_ascii (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       value_valid,
  output logic                       value_ready,
  input  logic [ida_pkg::DATA_W-1:0] value,
  output logic                       char_valid,
  input  logic                       char_ready,
  output logic [ida_pkg::CHAR_W-1:0] char_code,
  output logic                       last
);
  import ida_pkg::*;

  state_t              state;
  logic [DATA_W-1:0]   mag;
  logic                neg;
  logic                sign_pending;
  logic [IDX_W-1:0]    nd;
  logic [IDX_W-1:0]    idx;
  logic [DIGIT_W-1:0]  digits [MAX_DIGITS];

  logic                div_load;
  logic [DATA_W-1:0]   div_quot;
  logic [DIGIT_W-1:0]  div_rem;
  logic                emit_fire;

  ida_div10 u_div10 (
    .clk       (clk),
    .load      (div_load),
    .dividend  (mag),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign value_ready = (state == S_IDLE);
  assign div_load    = (state == S_MUL);
  assign emit_fire   = (state == S_EMIT) && (!char_valid || char_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      char_valid   <= 1'b0;
      sign_pending <= 1'b0;
    end else begin
      if (emit_fire) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (value_valid) begin
            neg   <= value[DATA_W-1];
            mag   <= value[DATA_W-1] ? (~value + 1'b1) : value;
            nd    <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          digits[nd] <= div_rem;
          mag        <= div_quot;
          if ((div_quot == '0) || (nd == IDX_W'(MAX_DIGITS - 1))) begin
            idx          <= nd;
            sign_pending <= neg;
            state        <= S_EMIT;
          end else begin
            nd    <= nd + 1'b1;
            state <= S_MUL;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            if (sign_pending) begin
              char_code    <= CH_MINUS;
              last         <= 1'b0;
              sign_pending <= 1'b0;
            end else begin
              char_code <= CH_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, digits[idx]};
              last      <= (idx == '0);
              if (idx == '0) begin
                state <= S_IDLE;
              end else begin
                idx <= idx - 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted value always goes straight into the divide loop.
  a_accept_to_mul: assert property (@(posedge clk) disable iff (rst)
    (value_valid && value_ready) |=> (state == S_MUL))
    else $error("accepted value did not start the divide loop");

  // The reciprocal multiply must leave a remainder that is a decimal digit.
  a_rem_is_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rem < DIGIT_W'(10)))
    else $error("divide unit produced a remainder above nine");

  // The final digit beat carries last and returns the sequencer to idle.
  a_last_ends_value: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && !sign_pending && (idx == '0)) |=> (last && char_valid && state == S_IDLE))
    else $error("final digit did not end the value");

  // The sign beat never carries last.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && sign_pending) |=> (!last && char_code == CH_MINUS))
    else $error("minus sign beat flagged as last");
`endif

endmodule
